### rtl/core/wmra_pkg.sv
// Package for the window motor request arbiter.
// Holds the word types, command and register codes and the flag layout.
// Has no dependencies; every module of the block imports it.
package wmra_pkg;

  localparam int unsigned MaskWidth = 16;

  // Constants used by reset values and the recent-stop compare.
  localparam logic [MaskWidth-1:0] ALL_ONES   = 16'hFFFF;
  localparam logic [MaskWidth:0]   RECENT_GAP = 17'd2;

  // Event codes carried in the cmd field of an input word.
  typedef enum logic [3:0] {
    CMD_SET_UP    = 4'd0,
    CMD_CLR_UP    = 4'd1,
    CMD_SET_DN    = 4'd2,
    CMD_CLR_DN    = 4'd3,
    CMD_SET_STOP  = 4'd4,
    CMD_CLR_STOP  = 4'd5,
    CMD_LOAD_DLY  = 4'd6,
    CMD_TICK      = 4'd7,
    CMD_TASK      = 4'd8
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_VALID_UP   = 3'd0,
    CFG_VALID_DN   = 3'd1,
    CFG_VALID_STOP = 3'd2,
    CFG_DELAY_MAX  = 3'd3,
    CFG_DIR_SWAP   = 3'd4
  } cfg_idx_t;

  // Bits of the hall action pulse field.
  localparam int unsigned ActReload = 0;
  localparam int unsigned ActSoft   = 1;
  localparam int unsigned ActBlock  = 2;
  localparam int unsigned ActDnCnt  = 3;
  localparam int unsigned ActUpCnt  = 4;
  localparam int unsigned ActBuf    = 5;

  typedef struct packed {
    logic [3:0]           cmd;
    logic [MaskWidth-1:0] request_bits;
    logic [MaskWidth-1:0] delay_value;
    logic                 relay_stuck;
    logic [MaskWidth-1:0] hall_position;
  } in_item_t;

  typedef struct packed {
    logic                 relay_a;
    logic                 relay_b;
    logic [2:0]           drive_flags;
    logic                 motor_running;
    logic                 moving_up;
    logic                 previous_up;
    logic [MaskWidth-1:0] delay_left;
    logic                 delay_recent;
    logic [MaskWidth-1:0] stop_position;
    logic [MaskWidth-1:0] stop_cause;
    logic [5:0]           hall_actions;
    logic [MaskWidth-1:0] active_request;
  } out_item_t;

  // Configuration values as seen by the arbiter.
  typedef struct packed {
    logic [MaskWidth-1:0] valid_up_mask;
    logic [MaskWidth-1:0] valid_down_mask;
    logic [MaskWidth-1:0] valid_stop_mask;
    logic [MaskWidth-1:0] stop_delay_max;
    logic                 direction_swap;
  } cfg_t;

  // Motor flag register layout.
  typedef struct packed {
    logic prev_up;
    logic up;
    logic run;
    logic stopped;
    logic opening;
    logic closing;
  } motor_flags_t;

endpackage

### rtl/core/wmra_cfg_regs.sv
// Configuration register file of the window motor request arbiter.
// Depends on wmra_pkg for the register codes and the cfg_t bundle.
module wmra_cfg_regs import wmra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  // Registers take a word on a completed write; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_up_mask   <= ALL_ONES;
      cfg.valid_down_mask <= ALL_ONES;
      cfg.valid_stop_mask <= ALL_ONES;
      cfg.stop_delay_max  <= '0;
      cfg.direction_swap  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_VALID_UP:   cfg.valid_up_mask   <= wr_data;
        CFG_VALID_DN:   cfg.valid_down_mask <= wr_data;
        CFG_VALID_STOP: cfg.valid_stop_mask <= wr_data;
        CFG_DELAY_MAX:  cfg.stop_delay_max  <= wr_data;
        CFG_DIR_SWAP:   cfg.direction_swap  <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/wmra_arbiter.sv
// Request masks, stop delay and motor state of the window motor arbiter.
// Applies one event per enabled cycle and forms the result word from the
// updated state. Depends on wmra_pkg.
module wmra_arbiter import wmra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  logic [15:0]  up_requests, down_requests, stop_requests;
  logic [15:0]  stop_delay, captured_position;
  motor_flags_t motor_flags;
  logic [1:0]   relay_pins;

  logic [15:0]  up_requests_next, down_requests_next, stop_requests_next;
  logic [15:0]  stop_delay_next, captured_position_next;
  motor_flags_t motor_flags_next;
  logic [1:0]   relay_pins_next;
  logic [5:0]   pulses;

  logic [15:0]  up_m, dn_m, st_m;
  logic         win_up, win_dn, go_dir;

  // Masked requests and the priority compare for a task.
  assign up_m   = up_requests & cfg.valid_up_mask;
  assign dn_m   = down_requests & cfg.valid_down_mask;
  assign st_m   = stop_requests & cfg.valid_stop_mask;
  assign win_up = (up_m > dn_m) && (up_m > st_m);
  assign win_dn = !(up_m > dn_m) && (dn_m > st_m);
  assign go_dir = win_up;

  // Next state for the current event.
  always_comb begin
    up_requests_next       = up_requests;
    down_requests_next     = down_requests;
    stop_requests_next     = stop_requests;
    stop_delay_next        = stop_delay;
    captured_position_next = captured_position;
    motor_flags_next       = motor_flags;
    relay_pins_next        = relay_pins;
    pulses                 = '0;
    case (item.cmd)
      CMD_SET_UP:   up_requests_next   = up_requests | item.request_bits;
      CMD_CLR_UP:   up_requests_next   = up_requests & ~item.request_bits;
      CMD_SET_DN:   down_requests_next = down_requests | item.request_bits;
      CMD_CLR_DN:   down_requests_next = down_requests & ~item.request_bits;
      CMD_SET_STOP: stop_requests_next = stop_requests | item.request_bits;
      CMD_CLR_STOP: stop_requests_next = stop_requests & ~item.request_bits;
      CMD_LOAD_DLY: begin
        stop_delay_next = (item.delay_value < cfg.stop_delay_max) ?
                          item.delay_value : cfg.stop_delay_max;
      end
      CMD_TICK: begin
        if (stop_delay != '0) begin
          stop_delay_next = stop_delay - 16'd1;
        end
      end
      CMD_TASK: begin
        if (!item.relay_stuck) begin
          up_requests_next   = up_m;
          down_requests_next = dn_m;
          stop_requests_next = st_m;
          if (win_up || win_dn) begin
            // A start is locked out while the delay runs.
            if (stop_delay == '0) begin
              pulses[ActBlock] = 1'b1;
              pulses[ActBuf]   = 1'b1;
              if (go_dir) begin
                pulses[ActDnCnt] = 1'b1;
              end else begin
                pulses[ActUpCnt] = 1'b1;
              end
              motor_flags_next.closing = go_dir;
              motor_flags_next.opening = !go_dir;
              motor_flags_next.stopped = 1'b0;
              motor_flags_next.up      = go_dir;
              motor_flags_next.run     = 1'b1;
              // Relay B carries up when swapped, down otherwise.
              relay_pins_next = ((cfg.direction_swap ? go_dir : !go_dir)) ?
                                2'b10 : 2'b01;
              if (!motor_flags.run) begin
                pulses[ActReload] = 1'b1;
                pulses[ActSoft]   = 1'b1;
              end
            end
          end else begin
            // Stop: a run that ends reloads the lockout and records itself.
            motor_flags_next.closing = 1'b0;
            motor_flags_next.opening = 1'b0;
            motor_flags_next.stopped = 1'b1;
            relay_pins_next          = 2'b00;
            pulses[ActReload]        = 1'b1;
            if (motor_flags.run) begin
              stop_delay_next          = cfg.stop_delay_max;
              motor_flags_next.run     = 1'b0;
              captured_position_next   = item.hall_position;
              motor_flags_next.prev_up = motor_flags.up;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_requests       <= '0;
      down_requests     <= '0;
      stop_requests     <= '0;
      stop_delay        <= '0;
      captured_position <= '0;
      motor_flags       <= '0;
      relay_pins        <= '0;
    end else if (advance) begin
      up_requests       <= up_requests_next;
      down_requests     <= down_requests_next;
      stop_requests     <= stop_requests_next;
      stop_delay        <= stop_delay_next;
      captured_position <= captured_position_next;
      motor_flags       <= motor_flags_next;
      relay_pins        <= relay_pins_next;
    end
  end

  // Result word from the updated state.
  always_comb begin
    res.relay_a        = relay_pins_next[0];
    res.relay_b        = relay_pins_next[1];
    res.drive_flags    = {motor_flags_next.stopped, motor_flags_next.opening,
                          motor_flags_next.closing};
    res.motor_running  = motor_flags_next.run;
    res.moving_up      = motor_flags_next.up;
    res.previous_up    = motor_flags_next.prev_up;
    res.delay_left     = stop_delay_next;
    res.delay_recent   = {1'b0, cfg.stop_delay_max} >=
                         ({1'b0, stop_delay_next} + RECENT_GAP);
    res.stop_position  = captured_position_next;
    res.stop_cause     = stop_requests_next;
    res.hall_actions   = pulses;
    res.active_request = up_requests_next;
  end

  // The run flag and a driven relay always go together.
  a_run_pins: assert property (@(posedge clk) disable iff (rst)
    motor_flags.run == (relay_pins != 2'b00))
    else $error("run flag and relay pins disagree");

  // Both relays are never driven at once.
  a_pins_excl: assert property (@(posedge clk) disable iff (rst)
    relay_pins != 2'b11)
    else $error("both relays driven");

  // A running motor is either closing or opening, never both.
  a_run_dir: assert property (@(posedge clk) disable iff (rst)
    motor_flags.run |-> $onehot({motor_flags.closing, motor_flags.opening}))
    else $error("running without a single direction flag");

  // State moves only when a word is processed.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stop_delay) && $stable(up_requests))
    else $error("state changed without a word");

endmodule

### rtl/core/window_motor_request_arbiter.sv
// Top level of the window motor request arbiter: input register, arbiter
// state and result register. Depends on wmra_pkg, wmra_cfg_regs, wmra_arbiter.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   item     | item_valid / item_stall     | item   (in_item_t)
//   result   | result_valid / result_stall | result (out_item_t)
//   config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Each word gives exactly one result word; result_valid rises once it has
// passed the input and result registers. One word per cycle is sustained
// while result_stall is low; the arbiter state is registered as a word
// moves on. Reset (rst, synchronous) clears masks, delay, flags and relays
// and loads the configuration defaults. A stalled result holds the result
// register; the input register fills and item_stall rises once it is full.
module window_motor_request_arbiter import wmra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_go;
  out_item_t core_res;

  assign cfg_ready = 1'b1;

  wmra_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input word moves on when the result register is free or drains.
  assign s1_go      = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  wmra_arbiter u_arb (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_go),
    .item    (s1_item),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result <= core_res;
    end
  end

endmodule
